FILE: design/ordered_key_list_engine_core_assert.svh
// Assertion macros shared by the list engine.
`ifndef ORDERED_KEY_LIST_ENGINE_CORE_ASSERT_SVH
`define ORDERED_KEY_LIST_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define OKLE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define OKLE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/okle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package okle_pkg;

  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_DEL_FRONT = 2'd1,
    OP_CONTAINS  = 2'd2,
    OP_DEL_KEY   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE  = 2'd0,
    FSM_CMP   = 2'd1,
    FSM_APPLY = 2'd2
  } fsm_e;

  typedef struct packed {
    op_e               op;
    logic signed [31:0] key;
  } req_t;

  typedef struct packed {
    logic       found;
    status_e    status;
    logic [4:0] entry_count;
  } resp_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic cmp_en;      // register the compare result
    logic load_front;  // take the word from the front neighbor
    logic pull_all;    // take the word from the back neighbor
    logic pull_match;  // take the back word at and behind the first hit
  } cell_cmd_t;

endpackage
`default_nettype wire

FILE: design/ordered_key_list_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Ordered key list engine: a list of up to DEPTH signed 32-bit keys, newest first.
// Command channel: req_i (op, key) is taken at a clock edge where start is high
// and busy is low. Ops: insert at front, delete front, contains, delete first match.
// Result channel: resp_o (found, status, entry_count) is valid for exactly one
// cycle while done_o is high; the receiver cannot stall it and must take it then.
// After acceptance the command passes the compare state and then the apply state,
// and done_o rises as the engine leaves the apply state. busy stays high through
// both states, so no new command is taken until the apply state is done.
// The steps follow the cell chain: every cell compares its key in parallel, then
// the first-hit flag ripples down the chain and the cells shift by one place where
// the op needs it, and the result word is shown while the engine is idle again.
// Reset clears the count and the control; cell contents are unknown and are
// only read below the count. No clearing pass is needed after reset.
module ordered_key_list_engine_core #(
  parameter int DEPTH = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire okle_pkg::req_t req_i,
  output logic                done_o,
  output okle_pkg::resp_t     resp_o
);
  import okle_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  fsm_e              state_q, state_d;
  req_t              req_q;
  logic [CW-1:0]     count_q, count_d;
  logic              done_q, done_d;
  resp_t             resp_q, resp_d;
  cell_cmd_t         cmd;

  logic signed [31:0] key_w [DEPTH];
  logic [DEPTH:0]     hit_w;
  logic [CW+4:0]      count_ext;

  logic accept;
  logic is_full, is_empty;

  assign accept   = start && !busy;
  assign is_full  = (count_q == CW'(DEPTH));
  assign is_empty = (count_q == '0);
  assign hit_w[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] prev_key, next_key;
    logic               occupied;

    assign occupied = (count_q > CW'(i));
    if (i == 0) begin : g_head
      assign prev_key = req_q.key;
    end else begin : g_mid
      assign prev_key = key_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_key = key_w[i];
    end else begin : g_body
      assign next_key = key_w[i+1];
    end

    okle_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .occupied_i   (occupied),
      .search_key_i (req_q.key),
      .prev_key_i   (prev_key),
      .next_key_i   (next_key),
      .hit_i        (hit_w[i]),
      .key_o        (key_w[i]),
      .hit_o        (hit_w[i+1])
    );
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    cmd       = '0;
    done_d    = 1'b0;
    resp_d    = resp_q;
    count_ext = '0;
    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          state_d = FSM_CMP;
        end
      end
      FSM_CMP: begin
        cmd.cmp_en = 1'b1;
        state_d    = FSM_APPLY;
      end
      FSM_APPLY: begin
        resp_d.found  = 1'b0;
        resp_d.status = ST_OK;
        case (req_q.op)
          OP_INSERT: begin
            if (is_full) begin
              resp_d.status = ST_FULL;
            end else begin
              cmd.load_front = 1'b1;
              count_d        = count_q + CW'(1);
            end
          end
          OP_DEL_FRONT: begin
            if (is_empty) begin
              resp_d.status = ST_EMPTY;
            end else begin
              cmd.pull_all = 1'b1;
              count_d      = count_q - CW'(1);
            end
          end
          OP_CONTAINS: begin
            resp_d.found = hit_w[DEPTH];
          end
          OP_DEL_KEY: begin
            if (is_empty) begin
              resp_d.status = ST_EMPTY;
            end else if (hit_w[DEPTH]) begin
              cmd.pull_match = 1'b1;
              count_d        = count_q - CW'(1);
              resp_d.found   = 1'b1;
            end
          end
          default: begin
            resp_d.status = ST_OK;
          end
        endcase
        count_ext          = {5'b0, count_d};
        resp_d.entry_count = count_ext[4:0];
        done_d             = 1'b1;
        state_d            = FSM_IDLE;
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Hold the command while it works through the chain.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    resp_q <= resp_d;
  end

  assign busy   = (state_q != FSM_IDLE);
  assign done_o = done_q;
  assign resp_o = resp_q;

`include "ordered_key_list_engine_core_assert.svh"

  `OKLE_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "count above depth")
  `OKLE_ASSERT_IMP(a_done_after_apply, done_q, $past(state_q) == FSM_APPLY, "stray result")
  `OKLE_ASSERT_IMP(a_full_means_full, done_q && resp_q.status == ST_FULL, is_full, "full with room")
  `OKLE_ASSERT_NXT(a_accept_busy, accept, busy && !done_q, "command not held busy")

endmodule
`default_nettype wire

FILE: design/okle_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module okle_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire okle_pkg::cell_cmd_t cmd_i,
  input  wire logic                occupied_i,
  input  wire logic signed [31:0]  search_key_i,
  input  wire logic signed [31:0]  prev_key_i,
  input  wire logic signed [31:0]  next_key_i,
  input  wire logic                hit_i,
  output logic signed [31:0]       key_o,
  output logic                     hit_o
);
  import okle_pkg::*;

  logic signed [31:0] key_q, key_d;
  logic               match_q, match_d;

  always_comb begin
    match_d = match_q;
    if (cmd_i.cmp_en) begin
      match_d = occupied_i && (key_q == search_key_i);
    end
    key_d = key_q;
    if (cmd_i.load_front) begin
      key_d = prev_key_i;
    end else if (cmd_i.pull_all || (cmd_i.pull_match && (hit_i || match_q))) begin
      key_d = next_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign key_o = key_q;
  // Pass the first-hit flag to the back neighbor.
  assign hit_o = hit_i || match_q;

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import okle_pkg::*;

  localparam int LIST_DEPTH  = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int BLOCKS      = 37;
  localparam int BLOCK_LEN   = 50;

  typedef struct packed {
    req_t        req;
    int unsigned gap;
    bit          drain;
  } cmd_item_t;

  logic  clk_i;
  logic  rst_ni = 1'b0;
  logic  start = 1'b0;
  req_t  cmd_word = '0;
  logic  busy;
  logic  done_o;
  resp_t resp_o;

  cmd_item_t          cmd_q[$];
  resp_t              owed_resps[$];
  logic signed [31:0] held_keys[$];
  logic signed [31:0] key_pool[8];

  int unsigned words_sent = 0;
  int unsigned words_recv = 0;
  int unsigned idle_cycles = 0;
  int unsigned cycle_cnt = 0;
  int          mismatches = 0;

  ordered_key_list_engine_core #(.DEPTH(LIST_DEPTH)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (cmd_word),
    .done_o(done_o),
    .resp_o(resp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int first_hit(logic signed [31:0] k);
    for (int i = 0; i < held_keys.size(); i++)
      if (held_keys[i] == k) return i;
    return -1;
  endfunction

  // Advance the list copy by one command and return the response it owes.
  function automatic resp_t list_step(req_t r);
    resp_t rsp;
    int    pos;
    rsp = '0;
    rsp.status = ST_OK;
    case (r.op)
      OP_INSERT: begin
        if (held_keys.size() >= LIST_DEPTH) rsp.status = ST_FULL;
        else held_keys.push_front(r.key);
      end
      OP_DEL_FRONT: begin
        if (held_keys.size() == 0) rsp.status = ST_EMPTY;
        else void'(held_keys.pop_front());
      end
      OP_CONTAINS: begin
        rsp.found = (first_hit(r.key) >= 0);
      end
      default: begin
        if (held_keys.size() == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          pos = first_hit(r.key);
          if (pos >= 0) begin
            held_keys.delete(pos);
            rsp.found = 1'b1;
          end
        end
      end
    endcase
    rsp.entry_count = 5'(held_keys.size());
    return rsp;
  endfunction

  task automatic queue_cmd(op_e op, logic signed [31:0] k, int unsigned gap, bit drain);
    cmd_item_t c;
    c.req.op  = op;
    c.req.key = k;
    c.gap     = gap;
    c.drain   = drain;
    cmd_q.push_back(c);
  endtask

  // Driver: hold a word until taken, then wait out the gap of the next one.
  always @(posedge clk_i or negedge rst_ni) begin : drive
    bit        took;
    cmd_item_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
      idle_cycles = 0;
    end else begin
      took = start && !busy;
      if (took) begin
        owed_resps.push_back(list_step(cmd_word));
        words_sent <= words_sent + 1;
      end
      if (!start || took) begin
        if (cmd_q.size() == 0) begin
          start <= 1'b0;
        end else if (cmd_q[0].drain && (words_sent + took) != words_recv) begin
          start <= 1'b0;
        end else if (idle_cycles < cmd_q[0].gap) begin
          idle_cycles++;
          start <= 1'b0;
        end else begin
          nxt = cmd_q.pop_front();
          cmd_word <= nxt.req;
          start <= 1'b1;
          idle_cycles = 0;
        end
      end
    end
  end

  // Monitor: every strobed word must match the oldest owed response.
  always @(posedge clk_i) begin : check
    resp_t want;
    if (rst_ni && done_o) begin
      words_recv <= words_recv + 1;
      if (owed_resps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: found=%0d status=%0d count=%0d",
                   resp_o.found, resp_o.status, resp_o.entry_count);
      end else begin
        want = owed_resps.pop_front();
        if (resp_o.found !== want.found || resp_o.status !== want.status ||
            resp_o.entry_count !== want.entry_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp found=%0d status=%0d count=%0d, got found=%0d status=%0d count=%0d",
                     want.found, want.status, want.entry_count,
                     resp_o.found, resp_o.status, resp_o.entry_count);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    int          bias;
    int          pick;
    bit          busy_gaps;
    op_e         op;
    logic signed [31:0] k;
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7fff_ffff;
    key_pool[2] = 32'sh0000_0000;
    key_pool[3] = -32'sd1;
    for (int i = 4; i < 8; i++) key_pool[i] = $urandom;

    // Empty-list corner cases, extremes, hits and misses, then fill past full.
    queue_cmd(OP_CONTAINS, 32'sd5, 0, 0);
    queue_cmd(OP_DEL_FRONT, 32'sd0, 0, 0);
    queue_cmd(OP_DEL_KEY, 32'sd5, 0, 0);
    queue_cmd(OP_INSERT, 32'sh8000_0000, 0, 0);
    queue_cmd(OP_INSERT, 32'sh7fff_ffff, 0, 0);
    queue_cmd(OP_INSERT, 32'sd0, 0, 0);
    queue_cmd(OP_INSERT, -32'sd1, 0, 0);
    queue_cmd(OP_CONTAINS, 32'sh7fff_ffff, 0, 0);
    queue_cmd(OP_CONTAINS, 32'sd1, 0, 0);
    queue_cmd(OP_CONTAINS, 32'sh8000_0000, 0, 0);
    queue_cmd(OP_DEL_KEY, 32'sd0, 0, 0);
    queue_cmd(OP_DEL_KEY, 32'sd7, 0, 0);
    queue_cmd(OP_DEL_FRONT, 32'sd0, 0, 0);
    for (int i = 0; i < 14; i++) queue_cmd(OP_INSERT, $urandom, 0, 0);
    queue_cmd(OP_INSERT, 32'sd42, 0, 0);
    queue_cmd(OP_CONTAINS, 32'sh8000_0000, 0, 0);
    queue_cmd(OP_DEL_KEY, 32'sh8000_0000, 0, 0);

    for (int b = 0; b < BLOCKS; b++) begin
      bias = $urandom_range(0, 2);
      busy_gaps = $urandom_range(0, 1);
      for (int n = 0; n < BLOCK_LEN; n++) begin
        pick = $urandom_range(0, 99);
        case (bias)
          0: op = pick < 55 ? OP_INSERT : pick < 65 ? OP_DEL_FRONT :
                  pick < 85 ? OP_CONTAINS : OP_DEL_KEY;
          1: op = pick < 20 ? OP_INSERT : pick < 50 ? OP_DEL_FRONT :
                  pick < 70 ? OP_CONTAINS : OP_DEL_KEY;
          default: op = pick < 30 ? OP_INSERT : pick < 50 ? OP_DEL_FRONT :
                        pick < 75 ? OP_CONTAINS : OP_DEL_KEY;
        endcase
        // Mostly reuse a small key set so lookups and deletes actually hit.
        k = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, 7)] : $urandom;
        queue_cmd(op, k, busy_gaps ? $urandom_range(0, 19) : 0, n == 0 && b % 6 == 0);
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || start || owed_resps.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    mismatches += owed_resps.size();

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
